// ===== sv/rc5_block_cipher_core_macros.svh =====
// ----------------------------------------------------------------------------
// RC5 block cipher core assertion macros
// Concurrent assertion wrappers; they compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RC5_BLOCK_CIPHER_CORE_MACROS_SVH
`define RC5_BLOCK_CIPHER_CORE_MACROS_SVH

`ifndef SYNTH
// Assert a property on every rising clock edge outside reset.
`define RC5_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Assert that a condition never holds outside reset.
`define RC5_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define RC5_ASSERT(label, clk, rst, prop, msg)
`define RC5_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

// ===== sv/rc5_pkg.sv =====
// ----------------------------------------------------------------------------
// RC5 block cipher package
// Sizes, schedule constants and word helpers shared by the cipher core.
// ----------------------------------------------------------------------------
package rc5_pkg;

   localparam int ROUNDS       = 12;
   localparam int KEY_BYTES    = 5;
   localparam int KEY_WIDTH    = 8 * KEY_BYTES;
   localparam int NUM_SUBKEYS  = 2 * (ROUNDS + 1);
   localparam int NUM_KWORDS   = (KEY_BYTES + 3) / 4;
   localparam int SUBKEY_IDX_W = $clog2(NUM_SUBKEYS);
   localparam int NUM_STEPS    = 3 * NUM_SUBKEYS;
   localparam int STEP_W       = $clog2(NUM_STEPS);
   localparam int NUM_STAGES   = 2 * ROUNDS + 2;

   localparam logic [31:0] RC5_P = 32'hB7E15163;
   localparam logic [31:0] RC5_Q = 32'h9E3779B9;

   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   typedef logic [31:0] word_type;
   typedef word_type rk_array_type [NUM_SUBKEYS];
   typedef word_type kw_array_type [2];

   function automatic word_type rotl32(input word_type x, input logic [4:0] n);
      logic [63:0] t;
      t = {x, x} << n;
      return t[63:32];
   endfunction

   function automatic word_type rotr32(input word_type x, input logic [4:0] n);
      logic [63:0] t;
      t = {x, x} >> n;
      return t[31:0];
   endfunction

   function automatic word_type bswap32(input word_type x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

   // Magic-constant ladder: P, P+Q, P+2Q, ...
   function automatic rk_array_type rk_init();
      rk_array_type rk;
      word_type     acc;
      acc = RC5_P;
      for (int i = 0; i < NUM_SUBKEYS; i++) begin
         rk[i] = acc;
         acc   = acc + RC5_Q;
      end
      return rk;
   endfunction

   // Pack key bytes into little-endian words, highest byte first.
   function automatic kw_array_type kw_init(input logic [KEY_WIDTH-1:0] key);
      kw_array_type kw;
      logic         wi;
      kw[0] = '0;
      kw[1] = '0;
      for (int idx = KEY_BYTES - 1; idx >= 0; idx--) begin
         wi     = 1'((idx >> 2) & 1);
         kw[wi] = rotl32(kw[wi], 5'd8) + {24'd0, key[8*idx +: 8]};
      end
      return kw;
   endfunction

endpackage

// ===== sv/rc5_block_cipher_core.sv =====
// ----------------------------------------------------------------------------
// RC5-32/12 block cipher core
// Pipelined encrypt/decrypt datapath with an on-chip key schedule.
// ----------------------------------------------------------------------------
// Each request carries a mode bit (0 encrypt, 1 decrypt) and one 64-bit block
// (word A in bits 63:32, word B in bits 31:0, each word byte-reversed); each
// request gives exactly one 64-bit response in the same packing. The datapath
// is a 26-stage pipeline: one stage for input whitening, one stage for each
// of the 24 half-rounds and one for output whitening, whose register drives
// the response. A new request enters every cycle unless a stalled response
// or the key schedule holds it off. A stalled response holds only the stages
// behind it that are full; bubbles still close up. After reset and after
// every key write the key schedule runs 78 mixing steps, each a subkey update
// then a key-word update, and req_ready stays low until it is done. Write the
// key only while no request is in flight.
// ----------------------------------------------------------------------------
`include "rc5_block_cipher_core_macros.svh"

module rc5_block_cipher_core
   import rc5_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_mode,
   input  logic [63:0]          req_block_in,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [63:0]          rsp_block_out,
   input  logic                 csr_wr_en,
   input  logic [KEY_WIDTH-1:0] csr_wr_data
);

   localparam int LAST = NUM_STAGES - 1;

   typedef enum logic {
      KS_IDLE,
      KS_RUN
   } ks_state_type;

   // ------------------------------------------------------------------------
   // Key schedule
   // ------------------------------------------------------------------------
   ks_state_type             ks_state_ff;
   logic [STEP_W-1:0]        step_ff;
   logic                     phase_ff;   // 0: update subkey, 1: update key word
   logic [SUBKEY_IDX_W-1:0]  si_ff;
   logic                     li_ff;
   logic [SUBKEY_IDX_W-1:0]  si_in;
   logic                     li_in;

   rk_array_type             rk_ff;
   kw_array_type             kw_ff;
   word_type                 ka_ff;
   word_type                 kb_ff;
   word_type                 ka_in;
   word_type                 kb_in;
   logic [KEY_WIDTH-1:0]     start_key;
   logic                     ks_start;
   logic                     ks_idle;

   assign ks_start  = reset || csr_wr_en;
   assign ks_idle   = (ks_state_ff == KS_IDLE);
   assign start_key = reset ? '0 : csr_wr_data;

   always_comb begin
      word_type   sum_a;
      word_type   sum_b;
      logic [4:0] amt;
      sum_a = rk_ff[si_ff] + ka_ff + kb_ff;
      ka_in = rotl32(sum_a, 5'd3);
      sum_b = kw_ff[li_ff] + ka_ff + kb_ff;
      amt   = ka_ff[4:0] + kb_ff[4:0];
      kb_in = rotl32(sum_b, amt);
      si_in = (si_ff == SUBKEY_IDX_W'(NUM_SUBKEYS - 1)) ? '0 : si_ff + 1'b1;
      li_in = (NUM_KWORDS == 1) ? 1'b0 : ~li_ff;
   end

   // Sequencer: restart on reset or key write; each mixing step is a subkey phase then a key-word phase.
   always_ff @(posedge clock) begin
      if (ks_start) begin
         ks_state_ff <= KS_RUN;
         step_ff     <= '0;
         phase_ff    <= 1'b0;
         si_ff       <= '0;
         li_ff       <= 1'b0;
      end else begin
         unique case (ks_state_ff)
            KS_IDLE: begin
               ks_state_ff <= KS_IDLE;
            end
            KS_RUN: begin
               phase_ff <= ~phase_ff;
               if (phase_ff) begin
                  step_ff <= step_ff + 1'b1;
                  si_ff   <= si_in;
                  li_ff   <= li_in;
                  if (step_ff == STEP_W'(NUM_STEPS - 1)) begin
                     ks_state_ff <= KS_IDLE;
                  end
               end
            end
            default: begin
               ks_state_ff <= KS_IDLE;
            end
         endcase
      end
   end

   // Subkey and key-word storage.
   always_ff @(posedge clock) begin
      if (ks_start) begin
         rk_ff <= rk_init();
         kw_ff <= kw_init(start_key);
         ka_ff <= '0;
         kb_ff <= '0;
      end else if (ks_state_ff == KS_RUN) begin
         if (!phase_ff) begin
            rk_ff[si_ff] <= ka_in;
            ka_ff        <= ka_in;
         end else begin
            kw_ff[li_ff] <= kb_in;
            kb_ff        <= kb_in;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Cipher pipeline
   // ------------------------------------------------------------------------
   logic     vld_ff   [NUM_STAGES];
   logic     mode_ff  [NUM_STAGES];
   word_type wa_ff    [NUM_STAGES];
   word_type wb_ff    [NUM_STAGES];
   word_type wa_in    [NUM_STAGES];
   word_type wb_in    [NUM_STAGES];
   logic     vld_in   [NUM_STAGES];
   logic     mode_in  [NUM_STAGES];
   logic     stage_en [NUM_STAGES];

   // A stage loads when it is empty or its content moves on.
   assign stage_en[LAST] = !vld_ff[LAST] || rsp_ready;

   generate
      for (genvar k = 0; k < LAST; k++) begin : g_en
         assign stage_en[k] = !vld_ff[k] || stage_en[k+1];
      end
   endgenerate

   assign req_ready = stage_en[0] && ks_idle;

   // Input whitening: unswap bytes, add the first two subkeys for encrypt.
   always_comb begin
      word_type a;
      word_type b;
      a = bswap32(req_block_in[63:32]);
      b = bswap32(req_block_in[31:0]);
      if (req_mode == MODE_ENCRYPT) begin
         a = a + rk_ff[0];
         b = b + rk_ff[1];
      end
      wa_in[0]   = a;
      wb_in[0]   = b;
      mode_in[0] = req_mode;
      vld_in[0]  = req_valid && ks_idle;
   end

   generate
      for (genvar k = 1; k <= 2 * ROUNDS; k++) begin : g_half
         localparam int J     = k - 1;
         localparam int ENC_R = J / 2 + 1;
         localparam int DEC_R = ROUNDS - J / 2;

         assign vld_in[k]  = vld_ff[k-1];
         assign mode_in[k] = mode_ff[k-1];

         if (J % 2 == 0) begin : g_even
            // Encrypt updates A; decrypt undoes B.
            always_comb begin
               if (mode_ff[k-1] == MODE_ENCRYPT) begin
                  wa_in[k] = rotl32(wa_ff[k-1] ^ wb_ff[k-1], wb_ff[k-1][4:0])
                             + rk_ff[2*ENC_R];
                  wb_in[k] = wb_ff[k-1];
               end else begin
                  wa_in[k] = wa_ff[k-1];
                  wb_in[k] = rotr32(wb_ff[k-1] - rk_ff[2*DEC_R+1], wa_ff[k-1][4:0])
                             ^ wa_ff[k-1];
               end
            end
         end else begin : g_odd
            // Encrypt updates B; decrypt undoes A.
            always_comb begin
               if (mode_ff[k-1] == MODE_ENCRYPT) begin
                  wa_in[k] = wa_ff[k-1];
                  wb_in[k] = rotl32(wb_ff[k-1] ^ wa_ff[k-1], wa_ff[k-1][4:0])
                             + rk_ff[2*ENC_R+1];
               end else begin
                  wa_in[k] = rotr32(wa_ff[k-1] - rk_ff[2*DEC_R], wb_ff[k-1][4:0])
                             ^ wb_ff[k-1];
                  wb_in[k] = wb_ff[k-1];
               end
            end
         end
      end
   endgenerate

   // Output whitening: drop the first two subkeys for decrypt.
   always_comb begin
      wa_in[LAST]   = wa_ff[LAST-1];
      wb_in[LAST]   = wb_ff[LAST-1];
      mode_in[LAST] = mode_ff[LAST-1];
      vld_in[LAST]  = vld_ff[LAST-1];
      if (mode_ff[LAST-1] == MODE_DECRYPT) begin
         wa_in[LAST] = wa_ff[LAST-1] - rk_ff[0];
         wb_in[LAST] = wb_ff[LAST-1] - rk_ff[1];
      end
   end

   generate
      for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else if (stage_en[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end

         always_ff @(posedge clock) begin
            if (stage_en[k]) begin
               mode_ff[k] <= mode_in[k];
               wa_ff[k]   <= wa_in[k];
               wb_ff[k]   <= wb_in[k];
            end
         end
      end
   endgenerate

   assign rsp_valid     = vld_ff[LAST];
   assign rsp_block_out = {bswap32(wa_ff[LAST]), bswap32(wb_ff[LAST])};

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // A key write always restarts the schedule.
   `RC5_ASSERT(a_write_restarts, clock, reset, csr_wr_en |=> (ks_state_ff == KS_RUN), "key write did not restart schedule")
   // The step counter never runs past the last mixing step.
   `RC5_ASSERT_NEVER(a_step_range, clock, reset, (ks_state_ff == KS_RUN) && (step_ff > STEP_W'(NUM_STEPS - 1)), "schedule step out of range")
   // A response waiting on a stalled consumer is not dropped.
   `RC5_ASSERT(a_rsp_kept, clock, reset, (vld_ff[LAST] && !rsp_ready) |=> vld_ff[LAST], "stalled response lost")
   // An accepted request always lands in the first stage.
   `RC5_ASSERT(a_req_lands, clock, reset, (req_valid && req_ready) |=> vld_ff[0], "accepted request lost at pipeline entry")

endmodule
